// ===== rtl/cnp_pkg.sv =====
// Shared types, constants and character helpers for the cpio newc stream parser.
package cnp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [6:0] HDR_LAST    = 7'd109;
	localparam logic [6:0] MAGIC_LEN   = 7'd6;
	localparam logic [6:0] FSIZE_FIRST = 7'd54;
	localparam logic [6:0] FSIZE_LAST  = 7'd61;
	localparam logic [6:0] NSIZE_FIRST = 7'd94;
	localparam logic [6:0] NSIZE_LAST  = 7'd101;
	localparam logic [3:0] TRAILER_LEN  = 4'd10;
	localparam logic [3:0] MATCH_FAILED = 4'd15;

	typedef enum logic [2:0] {
		K_NAME_CHAR = 3'd0,
		K_NAME_END  = 3'd1,
		K_DATA      = 3'd2,
		K_BAD_MAGIC = 3'd3,
		K_TRAILER   = 3'd4
	} cnp_kind_t;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_NAME    = 6'b000010,
		PH_NAMEPAD = 6'b000100,
		PH_DATA    = 6'b001000,
		PH_DATAPAD = 6'b010000,
		PH_HALT    = 6'b100000
	} cnp_phase_t;

	// One classified archive byte as it travels through the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [3:0] nibble;
		logic       is_nul;
	} cnp_item_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] r;
		r = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = 4'(c - 8'h37);
		end
		return r;
	endfunction

	// "070701"
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h30;
			3'd1: r = 8'h37;
			3'd2: r = 8'h30;
			3'd3: r = 8'h37;
			3'd4: r = 8'h30;
			3'd5: r = 8'h31;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "TRAILER!!!"
	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h54;
			4'd1: r = 8'h52;
			4'd2: r = 8'h41;
			4'd3: r = 8'h49;
			4'd4: r = 8'h4C;
			4'd5: r = 8'h45;
			4'd6: r = 8'h52;
			4'd7: r = 8'h21;
			4'd8: r = 8'h21;
			4'd9: r = 8'h21;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/cnp_front.sv =====
// Input side: accepts archive bytes and classifies them for the parser.
module cnp_front (
	input  logic                archive_valid,
	output logic                archive_ready,
	input  logic [7:0]          archive_byte,
	input  logic                archive_end,
	input  logic                full,
	output logic                push,
	output cnp_pkg::cnp_item_t  item
);

	assign archive_ready = !full;
	assign push          = archive_valid && !full;

	always_comb begin
		item.data   = archive_byte;
		item.last   = archive_end;
		item.nibble = cnp_pkg::hex_nibble(archive_byte);
		item.is_nul = (archive_byte == 8'h00);
	end

endmodule

// ===== rtl/cnp_queue.sv =====
// Small register queue between the classifier and the parser.
module cnp_queue #(
	parameter int unsigned DEPTH = cnp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cnp_pkg::cnp_item_t wr_item,
	input  logic               pop,
	output cnp_pkg::cnp_item_t rd_item,
	output logic               full,
	output logic               empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cnp_pkg::cnp_item_t slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/cnp_back.sv =====
// Parser state machine and registered result stage.
module cnp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  cnp_pkg::cnp_item_t item,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         kind,
	output logic [7:0]         value,
	output logic [31:0]        file_size,
	output logic               last_data
);

	cnp_pkg::cnp_phase_t phase_q, phase_d;
	logic [6:0]  pos_q, pos_d;
	logic [31:0] nsize_q, nsize_d;
	logic [31:0] dsize_q, dsize_d;
	logic [31:0] rem_q, rem_d;
	logic [1:0]  pad_q, pad_d;
	logic        nul_q, nul_d;
	logic [3:0]  tm_q, tm_d;

	logic        emit;
	logic [2:0]  kind_d;
	logic [7:0]  val_d;
	logic [31:0] fs_d;
	logic        last_d;
	logic        valid_q;

	logic [31:0] rem_dec;
	logic        rem_last;
	logic [1:0]  pad_dec;
	logic        go_np, go_d, go_dp;

	assign pop          = !empty && (!valid_q || result_ready);
	assign result_valid = valid_q;
	assign rem_dec      = rem_q - 32'd1;
	assign rem_last     = (rem_q == 32'd1);
	assign pad_dec      = pad_q - 2'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		nsize_d = nsize_q;
		dsize_d = dsize_q;
		rem_d   = rem_q;
		pad_d   = pad_q;
		nul_d   = nul_q;
		tm_d    = tm_q;
		emit    = 1'b0;
		kind_d  = cnp_pkg::K_NAME_CHAR;
		val_d   = 8'h00;
		fs_d    = 32'd0;
		last_d  = 1'b0;
		go_np   = 1'b0;
		go_d    = 1'b0;
		go_dp   = 1'b0;

		case (phase_q)
			cnp_pkg::PH_HEADER: begin
				if (pos_q < cnp_pkg::MAGIC_LEN &&
				    item.data != cnp_pkg::magic_char(pos_q[2:0])) begin
					phase_d = cnp_pkg::PH_HALT;
					emit    = 1'b1;
					kind_d  = cnp_pkg::K_BAD_MAGIC;
				end else begin
					if (pos_q inside {[cnp_pkg::FSIZE_FIRST:cnp_pkg::FSIZE_LAST]}) begin
						dsize_d = {dsize_q[27:0], item.nibble};
					end else if (pos_q inside {[cnp_pkg::NSIZE_FIRST:cnp_pkg::NSIZE_LAST]}) begin
						nsize_d = {nsize_q[27:0], item.nibble};
					end
					if (pos_q != cnp_pkg::HDR_LAST) begin
						pos_d = pos_q + 7'd1;
					end else begin
						pos_d   = '0;
						rem_d   = nsize_q;
						nul_d   = 1'b0;
						tm_d    = '0;
						phase_d = cnp_pkg::PH_NAME;
						// empty name: end it right here
						if (nsize_q == 32'd0) begin
							nul_d  = 1'b1;
							emit   = 1'b1;
							kind_d = cnp_pkg::K_NAME_END;
							fs_d   = dsize_q;
							go_np  = 1'b1;
						end
					end
				end
			end
			cnp_pkg::PH_NAME: begin
				rem_d = rem_dec;
				if (nul_q) begin
					go_np = rem_last;
				end else if (item.is_nul || rem_last) begin
					nul_d = 1'b1;
					emit  = 1'b1;
					if (tm_q == cnp_pkg::TRAILER_LEN) begin
						phase_d = cnp_pkg::PH_HALT;
						kind_d  = cnp_pkg::K_TRAILER;
					end else begin
						kind_d = cnp_pkg::K_NAME_END;
						fs_d   = dsize_q;
						go_np  = rem_last;
					end
				end else begin
					if (tm_q < cnp_pkg::TRAILER_LEN &&
					    item.data == cnp_pkg::trailer_char(tm_q)) begin
						tm_d = tm_q + 4'd1;
					end else begin
						tm_d = cnp_pkg::MATCH_FAILED;
					end
					emit   = 1'b1;
					kind_d = cnp_pkg::K_NAME_CHAR;
					val_d  = item.data;
				end
			end
			cnp_pkg::PH_NAMEPAD: begin
				pad_d = pad_dec;
				go_d  = (pad_dec == 2'd0);
			end
			cnp_pkg::PH_DATA: begin
				rem_d  = rem_dec;
				emit   = 1'b1;
				kind_d = cnp_pkg::K_DATA;
				val_d  = item.data;
				last_d = rem_last;
				go_dp  = rem_last;
			end
			cnp_pkg::PH_DATAPAD: begin
				pad_d = pad_dec;
				if (pad_dec == 2'd0) begin
					phase_d = cnp_pkg::PH_HEADER;
					pos_d   = '0;
				end
			end
			default: ;
		endcase

		// pad header plus name to a 4-byte boundary (header is 2 mod 4)
		if (go_np) begin
			pad_d = 2'd2 - nsize_q[1:0];
			if (pad_d != 2'd0) begin
				phase_d = cnp_pkg::PH_NAMEPAD;
			end else begin
				go_d = 1'b1;
			end
		end
		if (go_d) begin
			rem_d = dsize_q;
			if (dsize_q != 32'd0) begin
				phase_d = cnp_pkg::PH_DATA;
			end else begin
				go_dp = 1'b1;
			end
		end
		if (go_dp) begin
			pad_d = 2'd0 - dsize_q[1:0];
			if (pad_d != 2'd0) begin
				phase_d = cnp_pkg::PH_DATAPAD;
			end else begin
				phase_d = cnp_pkg::PH_HEADER;
				pos_d   = '0;
			end
		end

		// archive end: drop everything back to the reset state
		if (item.last) begin
			phase_d = cnp_pkg::PH_HEADER;
			pos_d   = '0;
			nsize_d = '0;
			dsize_d = '0;
			rem_d   = '0;
			pad_d   = '0;
			nul_d   = 1'b0;
			tm_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cnp_pkg::PH_HEADER;
			pos_q   <= '0;
			nsize_q <= '0;
			dsize_q <= '0;
			rem_q   <= '0;
			pad_q   <= '0;
			nul_q   <= 1'b0;
			tm_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				nsize_q <= nsize_d;
				dsize_q <= dsize_d;
				rem_q   <= rem_d;
				pad_q   <= pad_d;
				nul_q   <= nul_d;
				tm_q    <= tm_d;
				valid_q <= emit;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind      <= kind_d;
			value     <= val_d;
			file_size <= fs_d;
			last_data <= last_d;
		end
	end

endmodule

// ===== rtl/cpio_newc_stream_parser_core.sv =====
// Top level of the cpio newc stream parser.
//
// Usage: feed the archive one byte per transaction on the archive channel
// (archive_valid/archive_ready, archive_byte, archive_end). archive_end marks
// the final byte; after it the parser is back in its header state.
// Results leave on the result channel (result_valid/result_ready) with kind,
// value, file_size and last_data: name characters, a name-end carrying the
// file size, data bytes with the last one flagged, bad magic, or trailer.
// Bad magic and trailer halt the parser until the next archive_end.
//
// Throughput: one byte per cycle, sustained while result_ready is high.
// Header and pad bytes give no result. An accepted byte is written into the
// queue, and the parser registers its result once it pops that byte. A front
// classifier decodes hex digits and NUL, a QUEUE_DEPTH entry queue decouples
// it from the parser state machine, whose result register is the only output
// stage.
// When result_ready is low the parser holds its result and stops popping;
// the queue fills and then archive_ready drops.
// Reset clears the queue, the parser state and the result valid flag.
module cpio_newc_stream_parser_core #(
	parameter int unsigned QUEUE_DEPTH = cnp_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        archive_valid,
	output logic        archive_ready,
	input  logic [7:0]  archive_byte,
	input  logic        archive_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  kind,
	output logic [7:0]  value,
	output logic [31:0] file_size,
	output logic        last_data
);

	cnp_pkg::cnp_item_t wr_item, rd_item;
	logic push, pop, full, empty;

	cnp_front u_front (
		.archive_valid (archive_valid),
		.archive_ready (archive_ready),
		.archive_byte  (archive_byte),
		.archive_end   (archive_end),
		.full          (full),
		.push          (push),
		.item          (wr_item)
	);

	cnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.full    (full),
		.empty   (empty)
	);

	cnp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.item         (rd_item),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.value        (value),
		.file_size    (file_size),
		.last_data    (last_data)
	);

endmodule

// ===== rtl/cnp_checker.sv =====
// Port-level checks for the cpio newc stream parser, bound to the top level.
module cnp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  kind,
	input logic [7:0]  value,
	input logic [31:0] file_size,
	input logic        last_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind) &&
		$stable(value) && $stable(file_size) && $stable(last_data))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> kind != 3'd5 && kind != 3'd6 && kind != 3'd7)
		else $error("undefined result kind");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != cnp_pkg::K_NAME_CHAR && kind != cnp_pkg::K_DATA
		|-> value == 8'h00)
		else $error("value set on a non-byte result");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != cnp_pkg::K_DATA |-> !last_data)
		else $error("last_data outside data result");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != cnp_pkg::K_NAME_END |-> file_size == 32'd0)
		else $error("file_size set outside name end");

endmodule

bind cpio_newc_stream_parser_core cnp_checker u_cnp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.value        (value),
	.file_size    (file_size),
	.last_data    (last_data)
);

// ===== dv/cnp_parse_checker.sv =====
// Checker for the cpio newc stream parser: predicts results per archive byte, compares in order.
module cnp_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        archive_valid,
	input  logic        archive_ready,
	input  logic [7:0]  archive_byte,
	input  logic        archive_end,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  value,
	input  logic [31:0] file_size,
	input  logic        last_data,
	output int          mismatches,
	output int          pending,
	output int          checked,
	output int          name_ends,
	output int          trailers,
	output int          bad_magics,
	output int          data_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	import cnp_pkg::*;

	typedef struct packed {
		cnp_kind_t   kind;
		logic [7:0]  value;
		logic [31:0] size;
		logic        last;
	} parse_result_t;

	localparam logic [47:0] MAGIC_TEXT   = "070701";
	localparam logic [79:0] TRAILER_TEXT = "TRAILER!!!";
	localparam logic [31:0] HDR_BYTES    = 32'd110;

	// predicted parser state
	cnp_phase_t  phase;
	logic [6:0]  hdr_pos;
	logic [31:0] name_len;
	logic [31:0] file_len;
	logic [31:0] left;
	logic [1:0]  pad;
	logic        nul_seen;
	logic [3:0]  trl_match;

	parse_result_t parsed_q[$];

	int err_total;
	int n_checked;
	int n_name_end;
	int n_trailer;
	int n_bad_magic;
	int n_data;

	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c[3:0];
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return c[3:0] + 4'd9;
		return 4'd0;
	endfunction

	task automatic push_result(input cnp_kind_t k, input logic [7:0] v, input logic [31:0] s,
			input logic l);
		parse_result_t r;
		r.kind  = k;
		r.value = v;
		r.size  = s;
		r.last  = l;
		parsed_q.push_back(r);
	endtask

	task clear_parser();
		phase     = PH_HEADER;
		hdr_pos   = '0;
		name_len  = '0;
		file_len  = '0;
		left      = '0;
		pad       = '0;
		nul_seen  = 1'b0;
		trl_match = '0;
	endtask

	task to_header();
		phase   = PH_HEADER;
		hdr_pos = '0;
	endtask

	task start_data_pad();
		pad = 2'(-file_len);
		if (pad != 2'd0) phase = PH_DATAPAD;
		else to_header();
	endtask

	task start_data();
		left = file_len;
		if (file_len != 32'd0) phase = PH_DATA;
		else start_data_pad();
	endtask

	task start_name_pad();
		pad = 2'(-(HDR_BYTES + name_len));
		if (pad != 2'd0) phase = PH_NAMEPAD;
		else start_data();
	endtask

	// a full trailer match turns the name end into a trailer report and halts
	task end_name();
		nul_seen = 1'b1;
		if (trl_match == TRAILER_LEN) begin
			phase = PH_HALT;
			push_result(K_TRAILER, 8'd0, 32'd0, 1'b0);
		end else begin
			push_result(K_NAME_END, 8'd0, file_len, 1'b0);
		end
	endtask

	task parse_byte(input logic [7:0] b, input logic e);
		logic is_last;
		case (phase)
			PH_HEADER: begin
				if (hdr_pos < MAGIC_LEN && b != MAGIC_TEXT[47 - 8 * int'(hdr_pos) -: 8]) begin
					phase = PH_HALT;
					push_result(K_BAD_MAGIC, 8'd0, 32'd0, 1'b0);
				end else begin
					if (hdr_pos >= FSIZE_FIRST && hdr_pos <= FSIZE_LAST)
						file_len = {file_len[27:0], hex_digit(b)};
					else if (hdr_pos >= NSIZE_FIRST && hdr_pos <= NSIZE_LAST)
						name_len = {name_len[27:0], hex_digit(b)};
					if (hdr_pos != HDR_LAST) begin
						hdr_pos = hdr_pos + 7'd1;
					end else begin
						hdr_pos   = '0;
						left      = name_len;
						nul_seen  = 1'b0;
						trl_match = '0;
						phase     = PH_NAME;
						// empty name ends on the last header byte
						if (name_len == 32'd0) begin
							end_name();
							if (phase != PH_HALT) start_name_pad();
						end
					end
				end
			end
			PH_NAME: begin
				left    = left - 32'd1;
				is_last = (left == 32'd0);
				if (nul_seen) begin
					if (is_last) start_name_pad();
				end else if (b == 8'd0 || is_last) begin
					end_name();
					if (phase != PH_HALT && is_last) start_name_pad();
				end else begin
					if (trl_match < TRAILER_LEN && b == TRAILER_TEXT[79 - 8 * int'(trl_match) -: 8])
						trl_match = trl_match + 4'd1;
					else
						trl_match = MATCH_FAILED;
					push_result(K_NAME_CHAR, b, 32'd0, 1'b0);
				end
			end
			PH_NAMEPAD: begin
				pad = pad - 2'd1;
				if (pad == 2'd0) start_data();
			end
			PH_DATA: begin
				left    = left - 32'd1;
				is_last = (left == 32'd0);
				if (is_last) start_data_pad();
				push_result(K_DATA, b, 32'd0, is_last);
			end
			PH_DATAPAD: begin
				pad = pad - 2'd1;
				if (pad == 2'd0) to_header();
			end
			default: begin
			end
		endcase
		if (e) clear_parser();
	endtask

	task check_result();
		parse_result_t got;
		parse_result_t want;
		got.kind  = cnp_kind_t'(kind);
		got.value = value;
		got.size  = file_size;
		got.last  = last_data;
		if (parsed_q.size() == 0) begin
			if (err_total < 10)
				$display("%0t: unexpected result kind %0d value %02h size %08h last %0b",
					$realtime, kind, value, file_size, last_data);
			err_total++;
		end else begin
			want = parsed_q.pop_front();
			n_checked++;
			case (want.kind)
				K_NAME_END:  n_name_end++;
				K_TRAILER:   n_trailer++;
				K_BAD_MAGIC: n_bad_magic++;
				K_DATA:      n_data++;
				default: begin
				end
			endcase
			if (got.kind !== want.kind || got.value !== want.value ||
					got.size !== want.size || got.last !== want.last) begin
				if (err_total < 10)
					$display("%0t: mismatch: expected kind %0d value %02h size %08h last %0b, got kind %0d value %02h size %08h last %0b",
						$realtime, want.kind, want.value, want.size, want.last,
						kind, value, file_size, last_data);
				err_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			parsed_q.delete();
			err_total   = 0;
			n_checked   = 0;
			n_name_end  = 0;
			n_trailer   = 0;
			n_bad_magic = 0;
			n_data      = 0;
		end else begin
			if (archive_valid && archive_ready) parse_byte(archive_byte, archive_end);
			if (result_valid && result_ready) check_result();
		end
		mismatches <= err_total;
		pending    <= parsed_q.size();
		checked    <= n_checked;
		name_ends  <= n_name_end;
		trailers   <= n_trailer;
		bad_magics <= n_bad_magic;
		data_bytes <= n_data;
	end

endmodule

// ===== dv/cpio_newc_stream_parser_core_test.sv =====
// Testbench top for the cpio newc stream parser: archive stimulus, result stalls and verdict.
module cpio_newc_stream_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] MAGIC_TEXT   = "070701";
	localparam string       TRAILER_NAME = "TRAILER!!!";
	localparam int HDR_FIELDS  = 13;
	localparam int FSIZE_FIELD = 6;
	localparam int NSIZE_FIELD = 11;
	localparam int RANDOM_BYTES = 300;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_WINDOW} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        archive_valid = 1'b0;
	logic        archive_ready;
	logic [7:0]  archive_byte = 8'd0;
	logic        archive_end = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  value;
	logic [31:0] file_size;
	logic        last_data;

	int mismatches;
	int pending;
	int checked;
	int name_ends;
	int trailers;
	int bad_magics;
	int data_bytes;

	logic [7:0] arc_q[$];
	logic [7:0] name_q[$];
	int         hdr_starts[$];
	int         bytes_sent = 0;
	int         archives_sent = 0;
	int         burst_left = 0;
	rx_mode_t   rx_mode = RX_OPEN;
	int         rx_left = 0;

	cpio_newc_stream_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.archive_valid (archive_valid),
		.archive_ready (archive_ready),
		.archive_byte  (archive_byte),
		.archive_end   (archive_end),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.value         (value),
		.file_size     (file_size),
		.last_data     (last_data)
	);

	cnp_parse_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.archive_valid (archive_valid),
		.archive_ready (archive_ready),
		.archive_byte  (archive_byte),
		.archive_end   (archive_end),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.value         (value),
		.file_size     (file_size),
		.last_data     (last_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.checked       (checked),
		.name_ends     (name_ends),
		.trailers      (trailers),
		.bad_magics    (bad_magics),
		.data_bytes    (data_bytes)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: switch between stall styles every so often
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:  result_ready <= 1'b1;
			RX_LIGHT: result_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: result_ready <= ($urandom_range(0, 3) == 0);
			default:  result_ready <= (rx_left % 16) < 4;
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic e);
		if (burst_left == 0) begin
			archive_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		archive_valid <= 1'b1;
		archive_byte  <= b;
		archive_end   <= e;
		do @(posedge clk); while (!archive_ready);
		bytes_sent++;
	endtask

	// hold off until every predicted result has come back
	task automatic drain();
		archive_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		burst_left = 0;
	endtask

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom);
		while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
		return c;
	endfunction

	task automatic add_pad(input int n);
		for (int i = 0; i < n; i++) arc_q.push_back(8'($urandom));
	endtask

	task automatic add_hex(input logic [31:0] v, input bit garble);
		logic [3:0] nib;
		logic [7:0] ch;
		for (int i = 7; i >= 0; i--) begin
			nib = v[4 * i +: 4];
			if (nib < 4'd10) ch = "0" + 8'(nib);
			else ch = ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
			// a non-hex character still reads as a zero digit
			if (garble && nib == 4'd0 && $urandom_range(0, 1)) ch = non_hex_char();
			arc_q.push_back(ch);
		end
	endtask

	task automatic add_header(input logic [31:0] fsize, input logic [31:0] nsize,
			input bit garble);
		hdr_starts.push_back(arc_q.size());
		for (int i = 0; i < 6; i++) arc_q.push_back(MAGIC_TEXT[47 - 8 * i -: 8]);
		for (int f = 0; f < HDR_FIELDS; f++) begin
			if (f == FSIZE_FIELD) add_hex(fsize, garble);
			else if (f == NSIZE_FIELD) add_hex(nsize, garble);
			else add_pad(8);
		end
	endtask

	// name area takes name_q, then a NUL if room is left, then junk
	task automatic add_entry(input int nsize, input int fsize, input bit garble);
		add_header(fsize, nsize, garble);
		for (int i = 0; i < nsize; i++) begin
			if (i < name_q.size()) arc_q.push_back(name_q[i]);
			else if (i == name_q.size()) arc_q.push_back(8'd0);
			else arc_q.push_back(8'($urandom));
		end
		add_pad((4 - (110 + nsize) % 4) % 4);
		add_pad(fsize);
		add_pad((4 - fsize % 4) % 4);
	endtask

	task automatic name_text(input string s);
		name_q.delete();
		for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
	endtask

	task automatic name_random(input int len);
		name_q.delete();
		for (int i = 0; i < len; i++)
			name_q.push_back(($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
				: 8'($urandom_range(1, 255)));
		// some names follow the trailer name part or all of the way
		if ($urandom_range(0, 4) == 0)
			for (int i = 0; i < len && i < TRAILER_NAME.len(); i++) name_q[i] = TRAILER_NAME[i];
	endtask

	task automatic corrupt_magic(input int entry, input int pos);
		int at;
		at = hdr_starts[entry] + pos;
		arc_q[at] = arc_q[at] ^ 8'($urandom_range(1, 255));
	endtask

	// send the first keep bytes (all when keep is out of range), flag the last one
	task automatic flush_archive(input int keep);
		int n;
		n = (keep < 1 || keep > arc_q.size()) ? arc_q.size() : keep;
		for (int i = 0; i < n; i++) send_byte(arc_q[i], i == n - 1);
		arc_q.delete();
		hdr_starts.delete();
		archives_sent++;
	endtask

	task automatic random_archive();
		int entries;
		int nlen;
		int nsize;
		int fsize;
		if ($urandom_range(0, 11) == 0) begin
			add_pad($urandom_range(1, 20));
			flush_archive(0);
		end else begin
			entries = $urandom_range(1, 4);
			for (int k = 0; k < entries; k++) begin
				nlen = $urandom_range(0, 12);
				name_random(nlen);
				case ($urandom_range(0, 7))
					0:       nsize = nlen;
					1:       nsize = nlen + 1 + $urandom_range(1, 4);
					default: nsize = nlen + 1;
				endcase
				fsize = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				add_entry(nsize, fsize, $urandom_range(0, 1));
			end
			if ($urandom_range(0, 3) != 0) begin
				name_text(TRAILER_NAME);
				add_entry(11, 0, 1'b0);
			end
			add_pad($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				corrupt_magic($urandom_range(0, hdr_starts.size() - 1), $urandom_range(0, 5));
			flush_archive(($urandom_range(0, 7) == 0) ? $urandom_range(1, arc_q.size()) : 0);
		end
	endtask

	initial begin
		int rand_start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// bad magic at each of the six magic positions
		for (int p = 0; p < 6; p++) begin
			name_text("x");
			add_entry(2, 0, 1'b0);
			corrupt_magic(0, p);
			flush_archive(p + 3);
		end

		// empty name, missing NUL, junk after NUL, near and exact trailer names
		name_q.delete();
		add_entry(0, 0, 1'b1);
		name_text("a");
		add_entry(2, 1, 1'b0);
		name_text("abc");
		add_entry(3, 4, 1'b1);
		name_text("xy");
		add_entry(6, 5, 1'b0);
		name_text("TRAILER!!!X");
		add_entry(12, 0, 1'b0);
		name_text(TRAILER_NAME);
		add_entry(10, 0, 1'b0);
		add_pad(3);
		flush_archive(0);
		drain();

		// largest filesize, archive ends in the data
		add_header(32'hFFFF_FFFF, 32'd2, 1'b0);
		arc_q.push_back("z");
		arc_q.push_back(8'd0);
		add_pad(5);
		flush_archive(0);

		// largest namesize, archive ends in the name
		add_header(32'd0, 32'hFFFF_FFFF, 1'b1);
		add_pad(7);
		flush_archive(0);

		// archive ends in the header
		name_text("q");
		add_entry(2, 3, 1'b0);
		flush_archive(50);
		drain();

		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			random_archive();
			if (archives_sent % 5 == 0) drain();
		end
		drain();
		repeat (16) @(posedge clk);

		$display("Sent %0d archive bytes in %0d archives; checked %0d results.",
			bytes_sent, archives_sent, checked);
		$display("Covered %0d name ends, %0d data bytes, %0d trailers, %0d bad magic reports.",
			name_ends, data_bytes, trailers, bad_magics);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches, pending);
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d results outstanding", pending);
		$display("FAIL");
		$finish;
	end

endmodule
